// ----- design/ale_pkg.sv -----
// shared constants, codes and types of the array list engine
// no dependencies; compiled before every other file of the block

package ale_pkg;

  // storage geometry
  localparam int unsigned DEPTH      = 128;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 8;

  // width for comparing a position against the fill count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_READ   = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // one result item
  typedef struct packed {
    status_e                    status;
    logic [POS_W-1:0]           found_index;
    logic signed [VAL_W-1:0]    read_value;
    logic [COUNT_W-1:0]         count;
    logic                       is_empty;
    logic                       is_full;
  } res_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

endpackage

// ----- design/ale_if.sv -----
// valid/ready channel interfaces for list commands and list results
// depends on ale_pkg for the field widths

interface ale_in_if import ale_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface ale_out_if import ale_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        found_index;
  logic signed [VAL_W-1:0] read_value;
  logic [COUNT_W-1:0]      count;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, status, found_index, read_value, count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, found_index, read_value, count, is_empty, is_full,
                  output ready);
endinterface

// ----- design/ale_ram.sv -----
// generic single-write, single-read synchronous ram, registered read port
// no dependencies

module ale_ram #(
  parameter int unsigned WIDTH   = 32,
  parameter int unsigned ENTRIES = 128,
  localparam int unsigned AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [ENTRIES];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/ale_seq.sv -----
// command sequencer: fill count, read-modify-write over the entry ram
// depends on ale_pkg and ale_if; drives the ram through ram_req_t

module ale_seq import ale_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ale_in_if.sink                in_i,
  output res_t                  res_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output ram_req_t              ram_o,
  input  logic [DATA_WIDTH-1:0] ram_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_SEARCH = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  status_e               status_q, status_d;
  logic [IDX_W-1:0]      found_q, found_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;

  logic [CMP_W-1:0]      pos_w, cnt_w;
  logic                  in_range;
  logic [IDX_W-1:0]      addr;
  logic [DATA_WIDTH-1:0] data;
  logic [CNT_W-1:0]      next_idx;
  logic                  more;

  // decoded command fields
  assign pos_w    = CMP_W'(in_i.position);
  assign cnt_w    = CMP_W'(count_q);
  assign in_range = pos_w < cnt_w;
  assign addr     = IDX_W'(in_i.position);
  assign data     = DATA_WIDTH'(in_i.value);

  // scan progress: is there an entry after the current index
  assign next_idx = CNT_W'(idx_q) + CNT_W'(1);
  assign more     = next_idx < count_q;

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

  // sequencer next state and memory requests
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    key_d    = key_q;
    status_d = status_q;
    found_d  = found_q;
    rd_d     = rd_q;
    ram_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          key_d    = data;
          status_d = ST_OK;
          found_d  = '0;
          rd_d     = '0;
          state_d  = S_RESP;
          case (in_i.opcode)
            OP_APPEND: begin
              if (count_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ram_o.we    = 1'b1;
                ram_o.waddr = count_q[IDX_W-1:0];
                ram_o.wdata = data;
                count_d     = count_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (!in_range) begin
                status_d = ST_BAD_INDEX;
              end else if (pos_w + CMP_W'(1) == cnt_w) begin
                count_d = count_q - CNT_W'(1);
              end else begin
                ram_o.raddr = addr + IDX_W'(1);
                idx_d       = addr + IDX_W'(1);
                state_d     = S_SHIFT;
              end
            end
            OP_UPDATE: begin
              if (!in_range) begin
                status_d = ST_BAD_INDEX;
              end else begin
                ram_o.we    = 1'b1;
                ram_o.waddr = addr;
                ram_o.wdata = data;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                ram_o.raddr = '0;
                idx_d       = '0;
                state_d     = S_SEARCH;
              end
            end
            OP_READ: begin
              if (!in_range) begin
                status_d = ST_BAD_INDEX;
              end else begin
                ram_o.raddr = addr;
                state_d     = S_READ;
              end
            end
            default: begin
              // unused opcode: no change, plain ok result
            end
          endcase
        end
      end
      S_READ: begin
        rd_d    = ram_rdata_i;
        state_d = S_RESP;
      end
      S_SHIFT: begin
        // move the entry read last cycle one place down, fetch the next
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q - IDX_W'(1);
        ram_o.wdata = ram_rdata_i;
        if (more) begin
          ram_o.raddr = idx_q + IDX_W'(1);
          idx_d       = idx_q + IDX_W'(1);
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end
      S_SEARCH: begin
        if (ram_rdata_i == key_q) begin
          found_d = idx_q;
          state_d = S_RESP;
        end else if (more) begin
          ram_o.raddr = idx_q + IDX_W'(1);
          idx_d       = idx_q + IDX_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    status_q <= status_d;
    found_q  <= found_d;
    rd_q     <= rd_d;
  end

  // result item as seen after the operation
  always_comb begin
    res_o.status      = status_q;
    res_o.found_index = POS_W'(found_q);
    res_o.read_value  = VAL_W'(signed'(rd_q));
    res_o.count       = COUNT_W'(count_q);
    res_o.is_empty    = (count_q == '0);
    res_o.is_full     = (count_q == CNT_W'(DEPTH));
  end

endmodule

// ----- design/array_list_engine_unit.sv -----
// array list engine top level: command sequencer, entry ram, result register
// depends on ale_pkg, ale_if, ale_ram and ale_seq
//
// usage
//   in_i carries one command per transfer (opcode, position, value); out_o
//   returns exactly one result per command, in command order.
//   the list lives in a single ram of DEPTH entries with one write and one
//   registered read port; the fill count is a register.
// operation of each command
//   append, update: the entry is written directly; rejected, unused: no change
//   read: the entry comes back through the registered read port
//   search: entries from index 0 are compared until a match or the list end
//   remove: the entries after position move one place down, one per cycle
// throughput
//   one command at a time; in_i.ready returns on the edge at which the result
//   enters the output register, so the sequencer cannot take a new command
//   before it is through with the last one. the ram port pair, one entry per
//   cycle, sets the length of remove and search.
// reset
//   rst_ni clears the fill count, so the list is empty; ram contents stay
//   undefined and are never read before being written.
// stall
//   a result waiting on out_o does not block the next command; a second
//   finished result is held in the sequencer until out_o.ready.

module array_list_engine_unit import ale_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ale_in_if.sink   in_i,
  ale_out_if.source out_o
);

  res_t                  seq_res;
  logic                  seq_res_valid;
  logic                  seq_res_ready;
  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  out_valid_q;
  res_t                  out_res_q;

  // command sequencer
  ale_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_o       (seq_res),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // entry store
  ale_ram #(
    .WIDTH   (DATA_WIDTH),
    .ENTRIES (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // output register, free when empty or being drained this cycle
  assign seq_res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_valid && seq_res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      out_res_q <= seq_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_res_q.status;
  assign out_o.found_index = out_res_q.found_index;
  assign out_o.read_value  = out_res_q.read_value;
  assign out_o.count       = out_res_q.count;
  assign out_o.is_empty    = out_res_q.is_empty;
  assign out_o.is_full     = out_res_q.is_full;

  // checks

  // one command at a time: ready drops right after a command transfer
  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("command accepted while another is in progress");

  // fill count reported never exceeds the store size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.count <= COUNT_W'(DEPTH)))
    else $error("reported count above store depth");

  // a full report only comes with a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_FULL)) |-> out_o.is_full)
    else $error("full status on a list that is not full");

  // a found search result points inside the list
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.found_index != '0)) |->
      (COUNT_W'(out_o.found_index) < out_o.count))
    else $error("found index outside the list");

endmodule
